// ===== hdl/prc_pkg.sv =====
// Shared constants, FSM state type and controller/datapath interface structs.
`default_nettype none
package prc_pkg;
    localparam int MAX_POINTS_DEF  = 64;
    localparam int COORD_BITS_DEF  = 24;
    localparam int MIN_CLOSED      = 3;
    localparam int CFG_IDX_W       = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd3;

    localparam logic [1:0] SIDE_LAST = 2'd3;

    typedef enum logic [4:0] {
        S_LOAD, S_PINIT, S_PLAST, S_PCUR0, S_PNXT, S_PNXTW, S_EVAL,
        S_XSET, S_XMUL, S_XDST, S_XDIV, S_XPUT, S_ADV, S_PEND,
        S_OSTART, S_ORD, S_OWAIT, S_EMPTY
    } t_state;

    typedef struct packed {
        logic load;
        logic pinit;
        logic rd_last;
        logic cap_last;
        logic rd_first;
        logic cap_cur;
        logic rd_next;
        logic cap_next;
        logic eval;
        logic put_cur;
        logic x_set;
        logic x_np;
        logic x_mul;
        logic div_start;
        logic put_x;
        logic adv;
        logic pend;
        logic out_rd;
        logic out_load;
        logic out_empty;
        logic out_next;
        logic clear;
    } t_dp_cmd;

    typedef struct packed {
        logic n_zero;
        logic has_next;
        logic outside;
        logic pp_need;
        logic np_need;
        logic np_pend;
        logic div_done;
        logic side_last;
        logic out_free;
        logic out_last;
    } t_dp_stat;
endpackage
`default_nettype wire

// ===== hdl/prc_div.sv =====
// Restoring divider, one quotient bit per cycle; numerator high half below divisor.
`default_nettype none
module prc_div
    import prc_pkg::*;
#(
    parameter int W = COORD_BITS_DEF + 2
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [2*W-1:0] i_num,
    input  wire logic [W-1:0]   i_den,
    output logic                o_done,
    output logic [W-1:0]        o_quo
);
    localparam int CNTW = $clog2(W + 1);

    logic            r_busy, r_done;
    logic [CNTW-1:0] r_cnt;
    logic [W-1:0]    r_rem, r_lo, r_quo, r_den;
    logic [W:0]      w_sh, w_dif;

    assign w_sh  = {r_rem, r_lo[W-1]};
    assign w_dif = w_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[2*W-1:W];
            r_lo  <= i_num[W-1:0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_lo <= {r_lo[W-2:0], 1'b0};
            if (!w_dif[W]) begin
                r_rem <= w_dif[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[W-1:0];
                r_quo <= {r_quo[W-2:0], 1'b0};
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

// ===== hdl/prc_dpath.sv =====
// Clipper datapath: config, vertex stores, neighbor registers, crossing math, output word.
`default_nettype none
module prc_dpath
    import prc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [COORD_BITS-1:0] i_cfg_wdata,
    input  wire logic [COORD_BITS-1:0] i_in_x,
    input  wire logic [COORD_BITS-1:0] i_in_y,
    input  wire logic                  i_in_closed,
    input  wire t_dp_cmd               i_cmd,
    output t_dp_stat                   o_stat,
    input  wire logic                  i_out_ready,
    output logic                       o_out_valid,
    output logic [COORD_BITS:0]        o_out_x,
    output logic [COORD_BITS:0]        o_out_y,
    output logic                       o_out_has,
    output logic                       o_out_last,
    output logic                       o_out_chg,
    output logic                       o_out_ovf
);
    localparam int CB = COORD_BITS;
    localparam int CW = COORD_BITS + 1;
    localparam int D  = CW + 1;
    localparam int AW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);

    // configuration
    logic signed [CB-1:0] r_left, r_bottom;
    logic [CB-2:0]        r_width, r_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= '0;
            r_bottom <= '0;
            r_width  <= '0;
            r_height <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LEFT:   r_left   <= i_cfg_wdata;
                CFG_BOTTOM: r_bottom <= i_cfg_wdata;
                CFG_WIDTH:  r_width  <= i_cfg_wdata[CB-2:0];
                CFG_HEIGHT: r_height <= i_cfg_wdata[CB-2:0];
                default: ;
            endcase
        end
    end

    // control registers
    logic [NW-1:0] r_cnt, r_i, r_m, r_k;
    logic [1:0]    r_side;
    logic          r_src_b, r_skip, r_closed, r_chg, r_ovf, r_np_need;

    // vertex registers
    logic signed [CW-1:0] r_cur_x, r_cur_y, r_prv_x, r_prv_y, r_nxt_x, r_nxt_y;
    logic signed [CW-1:0] r_lst_x, r_lst_y, r_d0_x, r_d0_y, r_np_x, r_np_y;

    // crossing registers
    logic signed [CW-1:0] r_po;
    logic                 r_neg;
    logic [D-1:0]         r_ad, r_an, r_ac;
    logic [2*D-1:0]       r_prod;
    logic [D-1:0]         w_quo;
    logic                 w_div_done;

    // edge of the current side; even sides are the high edges
    logic signed [CW-1:0] w_base, w_span, w_edge;
    logic                 w_on_y, w_high;

    assign w_on_y = r_side[1];
    assign w_high = ~r_side[0];
    assign w_base = w_on_y ? {r_bottom[CB-1], r_bottom} : {r_left[CB-1], r_left};
    assign w_span = w_on_y ? {2'b00, r_height} : {2'b00, r_width};
    assign w_edge = w_high ? (w_base + w_span) : w_base;

    // classification of the current element
    logic signed [CW-1:0] w_cur_a, w_pp_x, w_pp_y, w_pp_a, w_npc_x, w_npc_y, w_npc_a;
    logic                 w_outside, w_has_pp, w_has_next, w_np_exists, w_pp_need, w_np_need;
    logic [NW-1:0]        w_i1;

    assign w_i1        = r_i + NW'(1);
    assign w_has_next  = w_i1 < r_cnt;
    assign w_cur_a     = w_on_y ? r_cur_y : r_cur_x;
    assign w_outside   = w_high ? (w_cur_a > w_edge) : (w_cur_a < w_edge);
    assign w_has_pp    = !r_skip && ((r_i != '0) || r_closed);
    assign w_pp_x      = (r_i != '0) ? r_prv_x : r_lst_x;
    assign w_pp_y      = (r_i != '0) ? r_prv_y : r_lst_y;
    assign w_pp_a      = w_on_y ? w_pp_y : w_pp_x;
    assign w_pp_need   = w_outside && w_has_pp &&
                         (w_high ? (w_pp_a < w_edge) : (w_pp_a > w_edge));
    // past the last element a closed run wraps to the first output, or to itself
    assign w_npc_x     = w_has_next ? r_nxt_x : ((r_m != '0) ? r_d0_x : r_cur_x);
    assign w_npc_y     = w_has_next ? r_nxt_y : ((r_m != '0) ? r_d0_y : r_cur_y);
    assign w_npc_a     = w_on_y ? w_npc_y : w_npc_x;
    assign w_np_exists = w_has_next || r_closed;
    assign w_np_need   = w_outside && w_np_exists &&
                         (w_high ? (w_npc_a < w_edge) : (w_npc_a > w_edge));

    // crossing operands
    logic signed [CW-1:0] w_q_x, w_q_y, w_po, w_qo, w_pa, w_qa;
    logic signed [D-1:0]  w_d, w_n, w_c;

    assign w_q_x = i_cmd.x_np ? r_np_x : w_pp_x;
    assign w_q_y = i_cmd.x_np ? r_np_y : w_pp_y;
    assign w_po  = w_on_y ? r_cur_x : r_cur_y;
    assign w_qo  = w_on_y ? w_q_x : w_q_y;
    assign w_pa  = w_on_y ? r_cur_y : r_cur_x;
    assign w_qa  = w_on_y ? w_q_y : w_q_x;
    assign w_d   = {w_po[CW-1], w_po} - {w_qo[CW-1], w_qo};
    assign w_n   = {w_pa[CW-1], w_pa} - {w_edge[CW-1], w_edge};
    assign w_c   = {w_pa[CW-1], w_pa} - {w_qa[CW-1], w_qa};

    always_ff @(posedge i_clk) begin
        if (i_cmd.x_set) begin
            r_po  <= w_po;
            r_neg <= w_d[D-1];
            r_ad  <= w_d[D-1] ? D'(-w_d) : D'(w_d);
            r_an  <= w_n[D-1] ? D'(-w_n) : D'(w_n);
            r_ac  <= w_c[D-1] ? D'(-w_c) : D'(w_c);
        end
        if (i_cmd.x_mul) begin
            r_prod <= r_ad * r_an;
        end
    end

    prc_div #(.W(D)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (r_prod),
        .i_den   (r_ac),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    logic [D-1:0]         w_xsum;
    logic signed [CW-1:0] w_xres, w_x_x, w_x_y, w_put_x, w_put_y;

    assign w_xsum  = r_neg ? ({r_po[CW-1], r_po} + w_quo) : ({r_po[CW-1], r_po} - w_quo);
    assign w_xres  = w_xsum[CW-1:0];
    assign w_x_x   = w_on_y ? w_xres : w_edge;
    assign w_x_y   = w_on_y ? w_edge : w_xres;
    assign w_put_x = i_cmd.put_cur ? r_cur_x : w_x_x;
    assign w_put_y = i_cmd.put_cur ? r_cur_y : w_x_y;

    // vertex stores, entries packed {y, x}
    logic [2*CW-1:0] mem_a [MAX_POINTS];
    logic [2*CW-1:0] mem_b [MAX_POINTS];
    logic [2*CW-1:0] r_rdata, w_wdata;
    logic [AW-1:0]   w_waddr, w_raddr;
    logic [NW-1:0]   w_raddr_n;
    logic            w_put, w_load_ok, w_put_ok, w_we_a, w_we_b, w_re;

    assign w_put     = i_cmd.put_cur || i_cmd.put_x;
    assign w_load_ok = r_cnt < NW'(MAX_POINTS);
    assign w_put_ok  = r_m < NW'(MAX_POINTS);
    assign w_we_a    = (i_cmd.load && w_load_ok) || (w_put && w_put_ok && r_src_b);
    assign w_we_b    = w_put && w_put_ok && !r_src_b;
    assign w_waddr   = i_cmd.load ? r_cnt[AW-1:0] : r_m[AW-1:0];
    assign w_wdata   = i_cmd.load ?
                       {i_in_y[CB-1], i_in_y, i_in_x[CB-1], i_in_x} : {w_put_y, w_put_x};

    always_comb begin
        if (i_cmd.rd_last)       w_raddr_n = r_cnt - NW'(1);
        else if (i_cmd.rd_next)  w_raddr_n = w_i1;
        else if (i_cmd.out_rd)   w_raddr_n = r_k;
        else                     w_raddr_n = '0;
    end
    assign w_raddr = w_raddr_n[AW-1:0];
    assign w_re    = i_cmd.rd_last || i_cmd.rd_first || i_cmd.rd_next || i_cmd.out_rd;

    always_ff @(posedge i_clk) begin
        if (w_we_a) mem_a[w_waddr] <= w_wdata;
        if (w_we_b) mem_b[w_waddr] <= w_wdata;
        if (w_re)   r_rdata <= r_src_b ? mem_b[w_raddr] : mem_a[w_raddr];
    end

    logic signed [CW-1:0] w_rx, w_ry;
    assign w_rx = r_rdata[CW-1:0];
    assign w_ry = r_rdata[2*CW-1:CW];

    // vertex registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_last) begin
            r_lst_x <= w_rx;
            r_lst_y <= w_ry;
        end
        if (i_cmd.cap_cur) begin
            r_cur_x <= w_rx;
            r_cur_y <= w_ry;
        end else if (i_cmd.adv) begin
            r_cur_x <= r_nxt_x;
            r_cur_y <= r_nxt_y;
        end
        if (i_cmd.adv) begin
            r_prv_x <= r_cur_x;
            r_prv_y <= r_cur_y;
        end
        if (i_cmd.cap_next) begin
            r_nxt_x <= w_rx;
            r_nxt_y <= w_ry;
        end
        if (i_cmd.eval) begin
            r_np_x <= w_npc_x;
            r_np_y <= w_npc_y;
        end
        if (w_put && w_put_ok && (r_m == '0)) begin
            r_d0_x <= w_put_x;
            r_d0_y <= w_put_y;
        end
    end

    // counters and flags
    logic [NW-1:0] w_cnt_after;
    assign w_cnt_after = w_load_ok ? (r_cnt + NW'(1)) : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_i       <= '0;
            r_m       <= '0;
            r_k       <= '0;
            r_side    <= '0;
            r_src_b   <= 1'b0;
            r_skip    <= 1'b0;
            r_closed  <= 1'b0;
            r_chg     <= 1'b0;
            r_ovf     <= 1'b0;
            r_np_need <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_cnt    <= w_cnt_after;
                r_closed <= i_in_closed && (w_cnt_after >= NW'(MIN_CLOSED));
                if (!w_load_ok) r_ovf <= 1'b1;
            end
            if (i_cmd.pinit) begin
                r_i    <= '0;
                r_m    <= '0;
                r_skip <= 1'b0;
            end
            if (i_cmd.eval) begin
                r_np_need <= w_np_need;
                r_skip    <= w_outside;
                if (w_outside) r_chg <= 1'b1;
            end
            if (w_put) begin
                if (w_put_ok) r_m <= r_m + NW'(1);
                else          r_ovf <= 1'b1;
            end
            if (i_cmd.adv) r_i <= w_i1;
            if (i_cmd.pend) begin
                r_cnt   <= r_m;
                r_side  <= r_side + 2'd1;
                r_src_b <= ~r_src_b;
            end
            if (i_cmd.out_next) r_k <= r_k + NW'(1);
            if (i_cmd.clear) begin
                r_cnt <= '0;
                r_k   <= '0;
                r_chg <= 1'b0;
                r_ovf <= 1'b0;
            end
        end
    end

    // output word
    logic                 r_ovalid, r_ohas, r_olast, r_ochg, r_oovf;
    logic signed [CW-1:0] r_ox, r_oy;
    logic                 w_out_free, w_out_last;

    assign w_out_free = !r_ovalid || i_out_ready;
    assign w_out_last = (r_k + NW'(1)) == r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load || i_cmd.out_empty) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_ox    <= w_rx;
            r_oy    <= w_ry;
            r_ohas  <= 1'b1;
            r_olast <= w_out_last;
            r_ochg  <= r_chg;
            r_oovf  <= r_ovf;
        end else if (i_cmd.out_empty) begin
            r_ox    <= '0;
            r_oy    <= '0;
            r_ohas  <= 1'b0;
            r_olast <= 1'b1;
            r_ochg  <= r_chg;
            r_oovf  <= r_ovf;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_out_x     = r_ox;
    assign o_out_y     = r_oy;
    assign o_out_has   = r_ohas;
    assign o_out_last  = r_olast;
    assign o_out_chg   = r_ochg;
    assign o_out_ovf   = r_oovf;

    always_comb begin
        o_stat.n_zero    = r_cnt == '0;
        o_stat.has_next  = w_has_next;
        o_stat.outside   = w_outside;
        o_stat.pp_need   = w_pp_need;
        o_stat.np_need   = w_np_need;
        o_stat.np_pend   = r_np_need;
        o_stat.div_done  = w_div_done;
        o_stat.side_last = r_side == SIDE_LAST;
        o_stat.out_free  = w_out_free;
        o_stat.out_last  = w_out_last;
    end
endmodule
`default_nettype wire

// ===== hdl/prc_ctrl.sv =====
// Clipper sequencer: load, four clipping passes, result emission.
`default_nettype none
module prc_ctrl
    import prc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire logic     i_in_last,
    output logic          o_in_ready,
    input  wire t_dp_stat i_stat,
    output t_dp_cmd       o_cmd,
    output t_state        o_state
);
    t_state r_state, n_state;
    logic   r_xnp, n_xnp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_xnp   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_xnp   <= n_xnp;
        end
    end

    always_comb begin
        n_state = r_state;
        n_xnp   = r_xnp;
        case (r_state)
            S_LOAD:   if (i_in_valid && i_in_last) n_state = S_PINIT;
            S_PINIT:  n_state = i_stat.n_zero ? S_PEND : S_PLAST;
            S_PLAST:  n_state = S_PCUR0;
            S_PCUR0:  n_state = S_PNXT;
            S_PNXT:   n_state = i_stat.has_next ? S_PNXTW : S_EVAL;
            S_PNXTW:  n_state = S_EVAL;
            S_EVAL: begin
                if (!i_stat.outside) begin
                    n_state = S_ADV;
                end else if (i_stat.pp_need) begin
                    n_xnp   = 1'b0;
                    n_state = S_XSET;
                end else if (i_stat.np_need) begin
                    n_xnp   = 1'b1;
                    n_state = S_XSET;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_XSET:   n_state = S_XMUL;
            S_XMUL:   n_state = S_XDST;
            S_XDST:   n_state = S_XDIV;
            S_XDIV:   if (i_stat.div_done) n_state = S_XPUT;
            S_XPUT: begin
                if (!r_xnp && i_stat.np_pend) begin
                    n_xnp   = 1'b1;
                    n_state = S_XSET;
                end else begin
                    n_state = S_ADV;
                end
            end
            S_ADV:    n_state = i_stat.has_next ? S_PNXT : S_PEND;
            S_PEND:   n_state = i_stat.side_last ? S_OSTART : S_PINIT;
            S_OSTART: n_state = i_stat.n_zero ? S_EMPTY : S_ORD;
            S_ORD:    n_state = S_OWAIT;
            S_OWAIT:  if (i_stat.out_free) n_state = i_stat.out_last ? S_LOAD : S_ORD;
            S_EMPTY:  if (i_stat.out_free) n_state = S_LOAD;
            default:  n_state = S_LOAD;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_LOAD: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_PINIT: begin
                o_cmd.pinit   = 1'b1;
                o_cmd.rd_last = 1'b1;
            end
            S_PLAST: begin
                o_cmd.cap_last = 1'b1;
                o_cmd.rd_first = 1'b1;
            end
            S_PCUR0:  o_cmd.cap_cur = 1'b1;
            S_PNXT:   o_cmd.rd_next = i_stat.has_next;
            S_PNXTW:  o_cmd.cap_next = 1'b1;
            S_EVAL: begin
                o_cmd.eval    = 1'b1;
                o_cmd.put_cur = !i_stat.outside;
            end
            S_XSET: begin
                o_cmd.x_set = 1'b1;
                o_cmd.x_np  = r_xnp;
            end
            S_XMUL:   o_cmd.x_mul = 1'b1;
            S_XDST:   o_cmd.div_start = 1'b1;
            S_XDIV:   ;
            S_XPUT:   o_cmd.put_x = 1'b1;
            S_ADV:    o_cmd.adv = 1'b1;
            S_PEND:   o_cmd.pend = 1'b1;
            S_OSTART: ;
            S_ORD:    o_cmd.out_rd = 1'b1;
            S_OWAIT: begin
                o_cmd.out_load = i_stat.out_free;
                o_cmd.out_next = i_stat.out_free && !i_stat.out_last;
                o_cmd.clear    = i_stat.out_free && i_stat.out_last;
            end
            S_EMPTY: begin
                o_cmd.out_empty = i_stat.out_free;
                o_cmd.clear     = i_stat.out_free;
            end
            default: ;
        endcase
    end

    assign o_state = r_state;
endmodule
`default_nettype wire

// ===== hdl/polyline_rect_clipper.sv =====
// Top level of the polyline rectangle clipper.
//
//  channel  | dir | handshake                      | word
//  ---------+-----+--------------------------------+-------------------------------------
//  s_axis   | in  | tvalid/tready                  | tdata {y, x}, tuser closed, tlast final
//  m_axis   | out | tvalid/tready                  | tdata {y, x}, tuser {ovf, chg, has}, tlast
//  cfg      | in  | i_cfg_we                       | i_cfg_idx, i_cfg_wdata
//
// Vertices are loaded back to back while the sequencer waits in its load state. Each of
// the four passes sets up, then walks the vertices and, for each intersection, waits
// for the bit-serial divider. Emission reads each result from the store, then loads it.
// Reset is synchronous; the vertex stores have no clearing pass.
// A stall on m_axis holds the sequencer before the next result is loaded.
`default_nettype none
module polyline_rect_clipper
    import prc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    // point_x, point_y
    input  wire logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // closed_shape
    input  wire logic                  s_axis_tuser,
    input  wire logic                  s_axis_tlast,
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // out_x, out_y
    output logic [((2*COORD_BITS+9)/8)*8-1:0] m_axis_tdata,
    // has_point, was_changed, overflowed
    output logic [2:0]                 m_axis_tuser,
    output logic                       m_axis_tlast,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [COORD_BITS-1:0] i_cfg_wdata
);
    localparam int OUT_TW = ((2*COORD_BITS+9)/8)*8;

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    t_state   w_state;
    logic [COORD_BITS:0] w_ox, w_oy;
    logic w_has, w_chg, w_ovf;

    // sequencer: hold each step until its datapath status allows the next
    prc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_state    (w_state)
    );

    // datapath: stores, crossing unit and the output word register
    prc_dpath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_x      (s_axis_tdata[COORD_BITS-1:0]),
        .i_in_y      (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .i_in_closed (s_axis_tuser),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_x     (w_ox),
        .o_out_y     (w_oy),
        .o_out_has   (w_has),
        .o_out_last  (m_axis_tlast),
        .o_out_chg   (w_chg),
        .o_out_ovf   (w_ovf)
    );

    // pack the result word, zero fill up to whole bytes
    assign m_axis_tdata = OUT_TW'({w_oy, w_ox});
    assign m_axis_tuser = {w_ovf, w_chg, w_has};

`ifndef NO_ASSERTIONS
    // an empty result is always the last of its run
    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
        else $error("empty result without tlast");

    // divider completion only while the sequencer waits for it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.div_done |-> w_state == S_XDIV)
        else $error("divider done outside its wait state");

    // a final vertex starts the first pass
    a_final_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> w_state == S_PINIT)
        else $error("final vertex did not start clipping");
`endif
endmodule
`default_nettype wire

// ===== tb/sv/polyline_rect_clipper_tb.sv =====
// Self-checking testbench for the polyline rectangle clipper: stream stimulus, local clip model.
`default_nettype none
module polyline_rect_clipper_tb;
    import prc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB      = COORD_BITS_DEF;
    localparam int NPTS    = MAX_POINTS_DEF;
    localparam int IN_W    = ((2*CB+7)/8)*8;
    localparam int OUT_W   = ((2*CB+9)/8)*8;
    localparam int OW      = CB + 1;
    // no-accept cycles: a full-size polyline with crossings everywhere stays far below this
    localparam int STALL_LIMIT = 200000;
    localparam int SETTLE  = 40;

    typedef struct {
        longint x;
        longint y;
    } t_vtx;

    typedef struct {
        logic [OW-1:0] x;
        logic [OW-1:0] y;
        logic          has;
        logic          last;
        logic          chg;
        logic          ovf;
    } t_clip_word;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata;
    logic              s_axis_tuser;
    logic              s_axis_tlast;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [OUT_W-1:0]  m_axis_tdata;
    logic [2:0]        m_axis_tuser;
    logic              m_axis_tlast;
    logic              i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CB-1:0]     i_cfg_wdata;

    polyline_rect_clipper DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Shadow of the rectangle registers and the vertex buffer
    longint     rect_lo_x, rect_lo_y, rect_w, rect_h;
    t_vtx       verts[NPTS];
    int         vert_cnt;
    bit         chg_flag, ovf_flag;
    t_clip_word clipped_q[$];

    int  n_items, n_polys, n_words, n_cfg, n_errors, n_ovf, n_empty;
    bit  idle_on;        // random gaps enabled on both sides
    int  hold_cycles;    // one-shot long stall request for the receiver
    int  quiet_cycles = 0;

    function automatic longint sx24(input logic [CB-1:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint mag(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // other-axis coordinate where p-q meets edge e; quotient truncates toward zero
    function automatic longint edge_cross(input longint po, qo, pa, qa, e);
        longint d, num, den, t;
        d   = po - qo;
        num = mag(d) * mag(pa - e);
        den = mag(pa - qa);
        t   = (den == 0) ? 0 : num / den;
        return (d < 0) ? po + t : po - t;
    endfunction

    // one side pass over verts[0:n-1]; side 0 right, 1 left, 2 top, 3 bottom
    task automatic clip_side(input int side, input bit closed, inout int n);
        t_vtx   src[NPTS];
        t_vtx   dst[NPTS];
        t_vtx   p, q, nb;
        bit     on_y, high, skip, outside, has_q, has_nb;
        longint e, v, a;
        int     m;
        src  = verts;
        on_y = side >= 2;
        high = (side % 2) == 0;
        e    = on_y ? (high ? rect_lo_y + rect_h : rect_lo_y)
                    : (high ? rect_lo_x + rect_w : rect_lo_x);
        m    = 0;
        skip = 1'b0;
        for (int i = 0; i < n; i++) begin
            p = src[i];
            v = on_y ? p.y : p.x;
            outside = high ? (v > e) : (v < e);
            if (!outside) begin
                if (m >= NPTS) ovf_flag = 1'b1;
                else begin dst[m] = p; m++; end
                skip = 1'b0;
                continue;
            end
            has_q  = 1'b0;
            has_nb = 1'b0;
            if (!skip) begin
                if (i > 0) begin q = src[i-1]; has_q = 1'b1; end
                else if (closed) begin q = src[n-1]; has_q = 1'b1; end
            end
            if (i + 1 < n) begin nb = src[i+1]; has_nb = 1'b1; end
            else if (closed) begin nb = (m > 0) ? dst[0] : p; has_nb = 1'b1; end
            for (int k = 0; k < 2; k++) begin
                if (k == 0 ? has_q : has_nb) begin
                    if (k == 1) q = nb;
                    a = on_y ? q.y : q.x;
                    if (high ? (a < e) : (a > e)) begin
                        if (m >= NPTS) ovf_flag = 1'b1;
                        else begin
                            if (on_y) begin
                                dst[m].x = edge_cross(p.x, q.x, p.y, q.y, e);
                                dst[m].y = e;
                            end else begin
                                dst[m].x = e;
                                dst[m].y = edge_cross(p.y, q.y, p.x, q.x, e);
                            end
                            m++;
                        end
                    end
                end
            end
            skip     = 1'b1;
            chg_flag = 1'b1;
        end
        verts = dst;
        n     = m;
    endtask

    // fold one accepted vertex into the model; on the last one queue the clipped words
    task automatic model_vertex(input logic [CB-1:0] px, py, input bit closed, is_last);
        t_clip_word w;
        int         n;
        bit         wrap;
        if (vert_cnt < NPTS) begin
            verts[vert_cnt].x = sx24(px);
            verts[vert_cnt].y = sx24(py);
            vert_cnt++;
        end else begin
            ovf_flag = 1'b1;
        end
        if (!is_last) return;
        n    = vert_cnt;
        wrap = closed && (n >= MIN_CLOSED);
        for (int side = 0; side < 4; side++) clip_side(side, wrap, n);
        if (n == 0) begin
            w = '{x: '0, y: '0, has: 1'b0, last: 1'b1, chg: chg_flag, ovf: ovf_flag};
            clipped_q.insert(clipped_q.size(), w);
            n_empty++;
        end
        for (int k = 0; k < n; k++) begin
            w.x = verts[k].x[OW-1:0];
            w.y = verts[k].y[OW-1:0];
            w.has = 1'b1;
            w.last = (k + 1 == n);
            w.chg = chg_flag;
            w.ovf = ovf_flag;
            clipped_q.insert(clipped_q.size(), w);
        end
        if (ovf_flag) n_ovf++;
        vert_cnt = 0;
        chg_flag = 1'b0;
        ovf_flag = 1'b0;
        n_polys++;
    endtask

    // ---------------- drivers ----------------
    task automatic send_vertex(input logic [CB-1:0] px, py, input bit closed, is_last);
        int gap;
        gap = idle_on ? $urandom_range(0, 13) : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            s_axis_tvalid = 1'b0;
            s_axis_tdata  = IN_W'({$urandom, $urandom});   // junk while idle
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        s_axis_tdata  = '0;
        s_axis_tdata[CB-1:0]    = px;
        s_axis_tdata[2*CB-1:CB] = py;
        s_axis_tuser  = closed;
        s_axis_tlast  = is_last;
        s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        model_vertex(px, py, closed, is_last);
        n_items++;
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    // wait for every queued word, then let the sequencer settle back to load
    task automatic drain();
        stop_sending();
        while (clipped_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CB-1:0] val);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        case (idx)
            CFG_LEFT:   rect_lo_x = sx24(val);
            CFG_BOTTOM: rect_lo_y = sx24(val);
            CFG_WIDTH:  rect_w    = longint'(val[CB-2:0]);
            CFG_HEIGHT: rect_h    = longint'(val[CB-2:0]);
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic set_rect(input longint lx, ly, w, h);
        write_reg(CFG_LEFT,   lx[CB-1:0]);
        write_reg(CFG_BOTTOM, ly[CB-1:0]);
        write_reg(CFG_WIDTH,  w[CB-1:0]);
        write_reg(CFG_HEIGHT, h[CB-1:0]);
    endtask

    // coordinate near [lo, lo+span], sometimes anywhere in the 24-bit range
    function automatic logic [CB-1:0] pick_coord(input longint lo, span);
        longint c;
        if ($urandom_range(0, 9) < 2) return CB'($urandom);
        c = lo - span / 2 - 2 + longint'($urandom_range(0, int'(2 * span + 4)));
        if (c > 8388607) c = 8388607;
        if (c < -8388608) c = -8388608;
        return c[CB-1:0];
    endfunction

    task automatic send_random_poly(input int len);
        bit closed;
        closed = $urandom_range(0, 1);
        for (int i = 0; i < len; i++)
            send_vertex(pick_coord(rect_lo_x, rect_w), pick_coord(rect_lo_y, rect_h),
                        (i + 1 == len) ? closed : bit'($urandom_range(0, 1)), i + 1 == len);
    endtask

    // ---------------- result side ----------------
    function automatic void cmp_field(input string name, input logic [OW-1:0] got, exp_v);
        if (got !== exp_v) begin
            $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, name, exp_v, got);
            n_errors++;
        end
    endfunction

    initial begin : receiver
        int gap;
        t_clip_word e;
        m_axis_tready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            gap = idle_on ? $urandom_range(0, 13) : 0;
            if (hold_cycles > 0) begin
                gap = hold_cycles;
                hold_cycles = 0;
            end
            if (gap > 0) begin
                @(negedge i_clk);
                m_axis_tready = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            n_words++;
            if (clipped_q.size() == 0) begin
                $display("%0t ns: unexpected word, expected none actual %0h/%0h", $time,
                         m_axis_tdata, m_axis_tuser);
                n_errors++;
            end else begin
                e = clipped_q.pop_front();
                cmp_field("out_x", m_axis_tdata[OW-1:0], e.x);
                cmp_field("out_y", m_axis_tdata[2*OW-1:OW], e.y);
                cmp_field("has_point", OW'(m_axis_tuser[0]), OW'(e.has));
                cmp_field("was_changed", OW'(m_axis_tuser[1]), OW'(e.chg));
                cmp_field("overflowed", OW'(m_axis_tuser[2]), OW'(e.ovf));
                cmp_field("end_of_run", OW'(m_axis_tlast), OW'(e.last));
            end
        end
    end

    // stall watchdog: any handshake restarts the count
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ---------------- tests ----------------
    task automatic test_basic_shapes();
        set_rect(-100, -50, 200, 150);           // x in [-100,100], y in [-50,100]
        send_vertex(24'd5, 24'd5, 1'b0, 1'b1);                           // single inside
        send_vertex(-24'sd300, 24'd0, 1'b0, 1'b0);                       // open, both ends out
        send_vertex(24'd0, 24'd7, 1'b0, 1'b0);
        send_vertex(24'd333, -24'sd91, 1'b0, 1'b1);
        send_vertex(24'd0, 24'd0, 1'b0, 1'b0);                           // closed triangle
        send_vertex(24'd250, 24'd40, 1'b0, 1'b0);
        send_vertex(24'd30, 24'd400, 1'b1, 1'b1);
        send_vertex(24'd500, 24'd500, 1'b1, 1'b0);                       // all outside: empty
        send_vertex(24'd600, 24'd520, 1'b1, 1'b1);
        send_vertex(24'd3, 24'd900, 1'b1, 1'b0);                         // two points, closed flag
        send_vertex(24'd4, 24'd1, 1'b1, 1'b1);
        send_vertex(24'h800000, 24'h7fffff, 1'b0, 1'b0);                 // field extremes
        send_vertex(24'h7fffff, 24'h800000, 1'b0, 1'b0);
        send_vertex(24'hffffff, 24'h000001, 1'b1, 1'b1);
        drain();
    endtask

    task automatic test_extreme_rects();
        set_rect(-8388608, -8388608, 8388607, 8388607);  // high edges at -1
        send_vertex(24'h800000, 24'h800000, 1'b0, 1'b0);
        send_vertex(24'h7fffff, 24'h7fffff, 1'b0, 1'b1);
        drain();
        set_rect(8388607, 8388607, 8388607, 8388607);    // high edges need 25 bits
        send_vertex(24'h7fffff, 24'h7fffff, 1'b0, 1'b1);
        drain();
        set_rect(0, 0, 0, 0);                            // rectangle collapsed to a point
        send_vertex(-24'sd5, 24'd5, 1'b1, 1'b0);
        send_vertex(24'd5, 24'd5, 1'b1, 1'b0);
        send_vertex(24'd0, -24'sd5, 1'b1, 1'b1);
        drain();
    endtask

    task automatic test_capacity();
        set_rect(-1000, -1000, 2000, 2000);
        // more vertices than the buffer holds; the dropped last one still starts clipping
        for (int i = 0; i < NPTS + 2; i++)
            send_vertex(24'(i * 7 - 200), 24'(i * 3), 1'b0, i == NPTS + 1);
        // closed zigzag: each outside vertex grows two crossings and overruns the buffer
        for (int i = 0; i < 60; i++)
            send_vertex((i % 2) ? 24'd5000 : 24'(i * 10 - 300), 24'(i * 20 - 600),
                        1'b1, i == 59);
        drain();
    endtask

    task automatic test_backpressure();
        set_rect(-500, -500, 1000, 1000);
        hold_cycles = 400;              // receiver sits out while input keeps coming
        for (int p = 0; p < 4; p++) send_random_poly($urandom_range(3, 6));
        drain();                        // sender pauses until everything is out
    endtask

    task automatic test_random_polylines(input int target);
        int      phase;
        longint  lx, ly, w, h;
        phase = 0;
        while (n_items < target) begin
            case ($urandom_range(0, 5))
                0: begin
                    lx = sx24(CB'($urandom)); ly = sx24(CB'($urandom));
                    w = $urandom_range(0, 8388607); h = $urandom_range(0, 8388607);
                end
                1: begin
                    lx = -8388608; ly = 8388607 - $urandom_range(0, 3);
                    w = 8388607; h = $urandom_range(0, 3);
                end
                default: begin
                    lx = longint'($urandom_range(0, 4000)) - 2000;
                    ly = longint'($urandom_range(0, 4000)) - 2000;
                    w  = $urandom_range(0, 3000); h = $urandom_range(0, 3000);
                end
            endcase
            set_rect(lx, ly, w, h);
            idle_on = (phase % 4) != 3;     // every fourth phase runs back to back
            for (int p = 0; p < 4; p++)
                send_random_poly(($urandom_range(0, 14) == 0) ? $urandom_range(30, 70)
                                                                : $urandom_range(1, 10));
            drain();
            phase++;
        end
        idle_on = 1'b1;
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0; s_axis_tuser = 1'b0; s_axis_tlast = 1'b0;
        i_cfg_we = 1'b0; i_cfg_idx = CFG_LEFT; i_cfg_wdata = '0;
        rect_lo_x = 0; rect_lo_y = 0; rect_w = 0; rect_h = 0;
        vert_cnt = 0; chg_flag = 1'b0; ovf_flag = 1'b0;
        n_items = 0; n_polys = 0; n_words = 0; n_cfg = 0; n_errors = 0;
        n_ovf = 0; n_empty = 0; hold_cycles = 0; idle_on = 1'b1;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_shapes();
        test_extreme_rects();
        test_capacity();
        test_backpressure();
        test_random_polylines(310);

        $display("Covered %0d vertices in %0d polylines, %0d clipped words, %0d register writes",
                 n_items, n_polys, n_words, n_cfg);
        $display("including %0d empty results and %0d truncated polylines", n_empty, n_ovf);
        if (n_errors == 0 && clipped_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/prc_pkg.sv
hdl/prc_div.sv
hdl/prc_dpath.sv
hdl/prc_ctrl.sv
hdl/polyline_rect_clipper.sv
tb/sv/polyline_rect_clipper_tb.sv
